// ===== hdl/tvap_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tvap_pkg
// Shared types and fixed constants for the time-varying all-pole filter.
// ----------------------------------------------------------------------------
package tvap_pkg;

	localparam int COEF_FIELDS = 8;
	localparam int COEF_BITS   = 16;
	localparam int FRAC_BITS   = 12;
	localparam int TAPS_W      = 4;

	localparam logic [TAPS_W-1:0] TAPS_RESET = 4'd8;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_FILTER = 1'b1;

	typedef logic signed [COEF_BITS-1:0] coef_t;

endpackage
// ----------------------------------------------------------------------------
`default_nettype wire

// ===== hdl/time_varying_allpole_filter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// time_varying_allpole_filter_core
// All-pole synthesis filter with per-sample coefficients, one shared MAC.
// ----------------------------------------------------------------------------
//  channel   handshake                 payload
//  in        in_valid / in_stall       operation, sample, coef_0..coef_7
//  out       out_valid / out_stall     filtered_sample, clipped
//  cfg       cfg_valid / cfg_ready     cfg_data (taps_in_use)
//
// A filter request walks ntaps = min(taps_in_use, ORDER, 8) taps on the
// single multiply-accumulate unit, one tap per cycle.
// Reset clears the history to zero and taps_in_use to 8.
// in_stall is high for the whole filter request; a finished result also waits
// in ST_DONE while the previous result is still held by out_stall.
// ----------------------------------------------------------------------------
module time_varying_allpole_filter_core
	import tvap_pkg::*;
#(
	parameter int ORDER       = 8,
	parameter int SAMPLE_BITS = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,

	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire                          operation,
	input  wire signed [SAMPLE_BITS-1:0] sample,
	input  wire signed [COEF_BITS-1:0]   coef_0,
	input  wire signed [COEF_BITS-1:0]   coef_1,
	input  wire signed [COEF_BITS-1:0]   coef_2,
	input  wire signed [COEF_BITS-1:0]   coef_3,
	input  wire signed [COEF_BITS-1:0]   coef_4,
	input  wire signed [COEF_BITS-1:0]   coef_5,
	input  wire signed [COEF_BITS-1:0]   coef_6,
	input  wire signed [COEF_BITS-1:0]   coef_7,

	output logic                         out_valid,
	input  wire                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] filtered_sample,
	output logic                         clipped,

	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire        [TAPS_W-1:0]      cfg_data
);

	localparam int NT     = (ORDER < COEF_FIELDS) ? ORDER : COEF_FIELDS;
	localparam int IDX_W  = $clog2(NT + 1);
	localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
	localparam int ACC_W  = PROD_W + 4;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (SAMPLE_BITS - 1)) - ACC_W'(1);
	localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DONE
	} state_t;

	state_t                          state_q;
	logic [TAPS_W-1:0]               taps_q;
	logic [IDX_W-1:0]                idx_q;
	logic [IDX_W-1:0]                ntaps_q;
	logic                            prod_vld_q;
	logic signed [PROD_W-1:0]        prod_q;
	logic signed [ACC_W-1:0]         acc_q;
	coef_t                           coef_q [COEF_FIELDS];
	logic signed [SAMPLE_BITS-1:0]   hist_q [ORDER];
	logic                            out_valid_q;
	logic signed [SAMPLE_BITS-1:0]   out_sample_q;
	logic                            out_clip_q;

	coef_t                           coef_in [COEF_FIELDS];
	coef_t                           c_sel;
	logic signed [SAMPLE_BITS-1:0]   h_sel;
	logic signed [ACC_W-1:0]         rnd;
	logic signed [SAMPLE_BITS-1:0]   y_sat;
	logic                            y_clip;
	logic [IDX_W-1:0]                ntaps_next;
	logic                            in_take;
	logic                            out_free;

	assign coef_in[0] = coef_0;
	assign coef_in[1] = coef_1;
	assign coef_in[2] = coef_2;
	assign coef_in[3] = coef_3;
	assign coef_in[4] = coef_4;
	assign coef_in[5] = coef_5;
	assign coef_in[6] = coef_6;
	assign coef_in[7] = coef_7;

	assign in_stall        = (state_q != ST_IDLE);
	assign in_take         = in_valid && !in_stall;
	assign cfg_ready       = 1'b1;
	assign out_valid       = out_valid_q;
	assign filtered_sample = out_sample_q;
	assign clipped         = out_clip_q;
	assign out_free        = !out_valid_q || !out_stall;

	always_comb begin
		if (taps_q > TAPS_W'(NT)) begin
			ntaps_next = IDX_W'(NT);
		end else begin
			ntaps_next = taps_q[IDX_W-1:0];
		end
	end

	// tap select for the shared multiplier
	always_comb begin
		h_sel = '0;
		c_sel = '0;
		for (int k = 0; k < NT; k++) begin
			if (idx_q == IDX_W'(k)) begin
				h_sel = hist_q[k];
				c_sel = coef_q[k];
			end
		end
	end

	// round half up, then saturate
	always_comb begin
		rnd = (acc_q + ROUND_HALF) >>> FRAC_BITS;
		if (rnd > SAT_HI) begin
			y_sat  = SAT_HI[SAMPLE_BITS-1:0];
			y_clip = 1'b1;
		end else if (rnd < SAT_LO) begin
			y_sat  = SAT_LO[SAMPLE_BITS-1:0];
			y_clip = 1'b1;
		end else begin
			y_sat  = rnd[SAMPLE_BITS-1:0];
			y_clip = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			taps_q      <= TAPS_RESET;
			idx_q       <= '0;
			ntaps_q     <= '0;
			prod_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int k = 0; k < ORDER; k++) begin
				hist_q[k] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				taps_q <= cfg_data;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					prod_vld_q <= 1'b0;
					if (in_take) begin
						if (operation == OP_FILTER) begin
							idx_q   <= '0;
							ntaps_q <= ntaps_next;
							state_q <= ST_MAC;
						end else begin
							for (int k = ORDER - 1; k > 0; k--) begin
								hist_q[k] <= hist_q[k-1];
							end
							hist_q[0] <= sample;
						end
					end
				end
				ST_MAC: begin
					if (idx_q < ntaps_q) begin
						prod_vld_q <= 1'b1;
						idx_q      <= idx_q + IDX_W'(1);
					end else begin
						prod_vld_q <= 1'b0;
						if (!prod_vld_q) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						for (int k = ORDER - 1; k > 0; k--) begin
							hist_q[k] <= hist_q[k-1];
						end
						hist_q[0]    <= y_sat;
						out_sample_q <= y_sat;
						out_clip_q   <= y_clip;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: coefficient capture, product and accumulator
	always_ff @(posedge clk) begin
		if (in_take && operation == OP_FILTER) begin
			for (int k = 0; k < COEF_FIELDS; k++) begin
				coef_q[k] <= coef_in[k];
			end
			acc_q <= {{(ACC_W - SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample} <<< FRAC_BITS;
		end else if (prod_vld_q) begin
			acc_q <= acc_q - {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
		end
		prod_q <= c_sel * h_sel;
	end

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

// ===== tb/time_varying_allpole_filter_core_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// time_varying_allpole_filter_core_tb
// Self-checking bench for the per-sample all-pole filter: directed corner
// requests, then random load/filter mixes over several tap counts, with
// random sender gaps and receiver stalls; outputs are checked in order
// against a cycle-free fixed-point model of the filter and its history.
// ----------------------------------------------------------------------------
module time_varying_allpole_filter_core_tb
	import tvap_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ORDER       = 8;
	localparam int SAMPLE_BITS = 16;
	localparam int SETTLE      = 24;
	localparam int MAX_PRINTS  = 40;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef coef_t coef_set_t [COEF_FIELDS];

	typedef struct {
		logic      op;
		sample_t   sample;
		coef_set_t coefs;
	} request_t;

	typedef struct {
		sample_t value;
		logic    clip;
	} expected_t;

	logic clk;
	logic arst_n = 1'b0;

	logic            in_valid  = 1'b0;
	logic            in_stall;
	request_t        req_drv;
	logic            out_valid;
	logic            out_stall = 1'b0;
	sample_t         filtered_sample;
	logic            clipped;
	logic            cfg_valid = 1'b0;
	logic            cfg_ready;
	logic [TAPS_W-1:0] cfg_data = '0;

	request_t  pending_requests [$];
	expected_t expected_outputs [$];
	sample_t   hist_model [ORDER];
	logic [TAPS_W-1:0] taps_model = TAPS_RESET;

	logic in_taken = 1'b0;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   hold_req = 0;
	int   hold_left = 0;
	int   errors = 0;

	time_varying_allpole_filter_core #(
		.ORDER(ORDER),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(req_drv.op),
		.sample(req_drv.sample),
		.coef_0(req_drv.coefs[0]),
		.coef_1(req_drv.coefs[1]),
		.coef_2(req_drv.coefs[2]),
		.coef_3(req_drv.coefs[3]),
		.coef_4(req_drv.coefs[4]),
		.coef_5(req_drv.coefs[5]),
		.coef_6(req_drv.coefs[6]),
		.coef_7(req_drv.coefs[7]),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.filtered_sample(filtered_sample),
		.clipped(clipped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (errors < MAX_PRINTS)
			$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	function automatic void history_push(input sample_t v);
		for (int i = ORDER - 1; i > 0; i--)
			hist_model[i] = hist_model[i-1];
		hist_model[0] = v;
	endfunction

	// Exact Q.27 sum, round half up to Q1.15, saturate; result feeds the history.
	function automatic expected_t filter_predict(input request_t r);
		longint    acc;
		longint    y;
		int        ntaps;
		expected_t e;
		ntaps = int'(taps_model);
		if (ntaps > ORDER)
			ntaps = ORDER;
		if (ntaps > COEF_FIELDS)
			ntaps = COEF_FIELDS;
		acc = longint'(r.sample) <<< FRAC_BITS;
		for (int i = 0; i < ntaps; i++)
			acc -= longint'(r.coefs[i]) * longint'(hist_model[i]);
		y = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		e.clip = 1'b0;
		if (y > 32767) begin
			y = 32767;
			e.clip = 1'b1;
		end
		if (y < -32768) begin
			y = -32768;
			e.clip = 1'b1;
		end
		e.value = sample_t'(y);
		history_push(e.value);
		return e;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
				req_drv = pending_requests.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with long hold-offs on request
	always @(negedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end else if (hold_left > 0) begin
			hold_left--;
		end
		out_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
	end

	// monitor
	always @(posedge clk) begin : monitor
		expected_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_outputs.size() == 0) begin
					report_mismatch($sformatf("unexpected result %0d clipped %0b",
						filtered_sample, clipped));
				end else begin
					e = expected_outputs.pop_front();
					if (filtered_sample !== e.value)
						report_mismatch($sformatf("filtered_sample %0d, want %0d",
							filtered_sample, e.value));
					if (clipped !== e.clip)
						report_mismatch($sformatf("clipped %0b, want %0b (sample %0d)",
							clipped, e.clip, e.value));
				end
			end
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				if (req_drv.op == OP_FILTER)
					expected_outputs.push_back(filter_predict(req_drv));
				else
					history_push(req_drv.sample);
			end
		end
	end

	task automatic add_request(input logic op, input sample_t s, input coef_set_t c);
		request_t r;
		r.op = op;
		r.sample = s;
		r.coefs = c;
		pending_requests.push_back(r);
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_outputs.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_taps(input logic [TAPS_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		taps_model = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic request_t random_request();
		request_t r;
		int       scale;
		r.op = ($urandom_range(99) < 25) ? OP_LOAD : OP_FILTER;
		if ($urandom_range(3) == 0)
			r.sample = sample_t'($urandom);
		else
			r.sample = $signed(16'($urandom)) >>> $urandom_range(15, 1);
		// mostly a gentle filter; sometimes full-range coefficients
		scale = ($urandom_range(3) == 0) ? 0 : $urandom_range(15, 2);
		foreach (r.coefs[i])
			r.coefs[i] = $signed(16'($urandom)) >>> scale;
		return r;
	endfunction

	task automatic run_random(input int n, input logic [TAPS_W-1:0] taps,
			input int idle, input int stall);
		write_taps(taps);
		idle_pct = idle;
		stall_pct = stall;
		repeat (n) pending_requests.push_back(random_request());
		wait_drained();
	endtask

	localparam coef_set_t ALL_MAX  = '{default: 16'sh7fff};
	localparam coef_set_t ALL_MIN  = '{default: 16'sh8000};
	localparam coef_set_t ALL_ZERO = '{default: 16'sh0000};
	localparam coef_set_t RAMP     = '{16'sd4096, -16'sd4096, 16'sd2048, 16'sd1024,
		16'sd512, 16'sd256, -16'sd128, 16'sd1};
	localparam coef_set_t HALF_POS = '{0: 16'sd2048, default: 16'sd0};
	localparam coef_set_t HALF_NEG = '{0: -16'sd2048, default: 16'sd0};
	localparam coef_set_t UNITY    = '{0: 16'sd4096, default: 16'sd0};
	localparam coef_set_t FIRST_MIN = '{0: 16'sh8000, default: 16'sd0};

	initial begin
		logic [TAPS_W-1:0] taps_list [8];
		int idle_list [4];
		int stall_list [4];
		taps_list  = '{4'd0, 4'd8, 4'd15, 4'd1, 4'd4, 4'd9, 4'd2, 4'd8};
		idle_list  = '{0, 58, 0, 29};
		stall_list = '{0, 0, 58, 29};
		req_drv.op = OP_LOAD;
		req_drv.sample = '0;
		req_drv.coefs = ALL_ZERO;
		foreach (hist_model[i])
			hist_model[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset tap count, zero history
		add_request(OP_FILTER, 16'sd100, ALL_MAX);
		add_request(OP_LOAD, 16'sd12345, ALL_ZERO);
		add_request(OP_LOAD, -16'sd16384, ALL_MAX);
		add_request(OP_LOAD, 16'sd16384, ALL_ZERO);
		add_request(OP_LOAD, -16'sd1, ALL_MIN);
		add_request(OP_LOAD, 16'sd1, ALL_ZERO);
		add_request(OP_LOAD, 16'sd0, ALL_ZERO);
		add_request(OP_LOAD, 16'sh8000, ALL_ZERO);
		add_request(OP_LOAD, 16'sh7fff, ALL_ZERO);
		add_request(OP_FILTER, 16'sd0, ALL_MAX);
		add_request(OP_FILTER, 16'sd0, ALL_MIN);
		add_request(OP_FILTER, 16'sh7fff, ALL_ZERO);
		add_request(OP_FILTER, 16'sh8000, ALL_ZERO);
		add_request(OP_FILTER, 16'sd1234, RAMP);
		// rounding ties at -0.5 and +0.5
		add_request(OP_LOAD, 16'sd1, ALL_ZERO);
		add_request(OP_FILTER, 16'sd0, HALF_POS);
		add_request(OP_LOAD, 16'sd1, ALL_ZERO);
		add_request(OP_FILTER, 16'sd0, HALF_NEG);
		// exact cancellation at the negative extreme
		add_request(OP_LOAD, 16'sh8000, ALL_ZERO);
		add_request(OP_FILTER, 16'sh8000, UNITY);
		add_request(OP_FILTER, 16'sh7fff, FIRST_MIN);
		wait_drained();

		// no taps: pass-through
		write_taps(4'd0);
		add_request(OP_FILTER, 16'sh8000, ALL_MAX);
		add_request(OP_FILTER, 16'sh7fff, ALL_MIN);
		add_request(OP_FILTER, -16'sd5, RAMP);
		wait_drained();
		// too many taps, cut to eight
		write_taps(4'd15);
		add_request(OP_FILTER, 16'sd777, RAMP);
		add_request(OP_FILTER, -16'sd777, RAMP);
		wait_drained();
		write_taps(4'd9);
		add_request(OP_FILTER, 16'sd300, RAMP);
		wait_drained();
		write_taps(4'd1);
		add_request(OP_FILTER, 16'sd300, RAMP);
		add_request(OP_FILTER, 16'sh7fff, ALL_MIN);
		wait_drained();

		// long receiver hold-off while the sender keeps offering
		write_taps(4'd8);
		idle_pct = 0;
		stall_pct = 0;
		repeat (40) pending_requests.push_back(random_request());
		hold_req = 400;
		wait_drained();

		for (int p = 0; p < 8; p++)
			run_random(200, taps_list[p], idle_list[p % 4], stall_list[p % 4]);

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/tvap_pkg.sv
hdl/time_varying_allpole_filter_core.sv
tb/time_varying_allpole_filter_core_tb.sv
